// ===== hw/rtl/imfit_pkg.sv =====
// Shared types and constants for the image fit rectangle calculator.
// Used by image_fit_rect_calc; no other dependencies.
`default_nettype none

package imfit_pkg;

  localparam int SRC_W   = 16;  // source size, whole pixels
  localparam int FRAME_W = 20;  // frame and destination sizes, Q16.4
  localparam int SCALE_W = 16;  // scale divisor, Q8.8
  localparam int SCL_W   = 28;  // scaled source size, Q.4, full width
  localparam int PROD_W  = FRAME_W + SCL_W;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE     = 1'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  typedef enum logic [2:0] {
    FIT_FILL       = 3'd0,
    FIT_CONTAIN    = 3'd1,
    FIT_COVER      = 3'd2,
    FIT_MATCH_W    = 3'd3,
    FIT_MATCH_H    = 3'd4,
    FIT_NONE       = 3'd5,
    FIT_SCALE_DOWN = 3'd6,
    FIT_TOP_LEFT   = 3'd7
  } fit_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_SW,
    ST_DIV_SH,
    ST_CHECK,
    ST_MUL_HW,
    ST_PRE_HW,
    ST_DIV_HW,
    ST_MUL_VH,
    ST_PRE_VH,
    ST_DIV_VH,
    ST_FIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [SRC_W-1:0]   src_width;
    logic [SRC_W-1:0]   src_height;
    logic [FRAME_W-1:0] frame_width;
    logic [FRAME_W-1:0] frame_height;
  } in_t;

  typedef struct packed {
    logic                      status;
    logic signed [FRAME_W-1:0] dst_x;
    logic signed [FRAME_W-1:0] dst_y;
    logic [FRAME_W-1:0]        dst_width;
    logic [FRAME_W-1:0]        dst_height;
  } out_t;

endpackage

`default_nettype wire

// ===== hw/rtl/image_fit_rect_calc.sv =====
// Image fit rectangle calculator: scales a source size, fits it into a frame.
// Depends on imfit_pkg for payload types, state and fit mode codes.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data) takes one source size and frame
//   size per transfer; output channel (out_valid/out_ready/out_data) returns
//   one destination rectangle per item. cfg_we/cfg_index/cfg_data write the
//   scale divisor (index 0, zero ignored) and the fit mode (index 1).
//   One restoring divider, one quotient bit per cycle, does all four divisions
//   in turn, with a single multiplier forming the cross products:
//   28 + 28 steps for the scaled source, 20 + 20 steps for the two aspect
//   terms (skipped when the quotient saturates), plus the check, multiply,
//   pre-check and fit states; a zero scaled size skips the aspect terms.
//   in_ready is high only while the sequencer is idle, so a new item is not
//   taken until the last one is finished. The output register frees the
//   sequencer: a new item is taken while a result waits, and the sequencer
//   holds its finished result until the receiver takes the previous one.
//   The output register also keeps the last good rectangle; an item whose
//   scaled width or height is zero returns it again with status 1.
//   Reset (rst, synchronous) restores the register defaults, clears the held
//   rectangle to zero and empties the output register.
`default_nettype none

module image_fit_rect_calc
  import imfit_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire in_t                  in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      out_t                 out_data,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [SCALE_W-1:0]   cfg_data
);

  localparam int SRC_STEPS = SCL_W;
  localparam int FIT_STEPS = FRAME_W;
  localparam int CNT_W     = $clog2(SRC_STEPS);
  localparam logic [CNT_W-1:0] SRC_LAST = CNT_W'(SRC_STEPS - 1);
  localparam logic [CNT_W-1:0] FIT_LAST = CNT_W'(FIT_STEPS - 1);
  localparam logic [FRAME_W-1:0] SIZE_MAX = {FRAME_W{1'b1}};

  state_t state, state_next;

  logic [SCALE_W-1:0] scale_factor;
  fit_mode_t          fit_mode;

  logic [SRC_W-1:0]   src_h;
  logic [FRAME_W-1:0] fw, fh;
  logic [SCL_W-1:0]   sw, sh;
  logic [FRAME_W-1:0] hw, vh;     // aspect terms, saturated
  logic [FRAME_W-1:0] dw, dh;
  logic               corner;
  logic               zero_size;
  logic [PROD_W-1:0]  prod;

  // shared divider
  logic [SCL_W-1:0] rem, dq;
  logic [CNT_W-1:0] cnt;
  logic [SCL_W-1:0] div_d;
  logic [SCL_W:0]   div_t;
  logic             div_ge;
  logic [SCL_W-1:0] rem_next, dq_next;

  // shared multiplier
  logic [FRAME_W-1:0] mul_a;
  logic [SCL_W-1:0]   mul_b;
  logic [PROD_W-1:0]  mul_p;

  logic               div_last;
  logic               out_free;
  logic               pre_sat;
  logic [FRAME_W-1:0] sw_sat, sh_sat;
  logic [FRAME_W-1:0] dw_fit, dh_fit;
  logic signed [FRAME_W:0] diff_x, diff_y;

  assign out_free = !out_valid || out_ready;

  // ---------------- next state ----------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DIV_SW;
      ST_DIV_SW: if (div_last) state_next = ST_DIV_SH;
      ST_DIV_SH: if (div_last) state_next = ST_CHECK;
      ST_CHECK: begin
        if (sw == '0 || sh == '0) state_next = ST_DONE;
        else state_next = ST_MUL_HW;
      end
      ST_MUL_HW: state_next = ST_PRE_HW;
      ST_PRE_HW: state_next = pre_sat ? ST_MUL_VH : ST_DIV_HW;
      ST_DIV_HW: if (div_last) state_next = ST_MUL_VH;
      ST_MUL_VH: state_next = ST_PRE_VH;
      ST_PRE_VH: state_next = pre_sat ? ST_FIT : ST_DIV_VH;
      ST_DIV_VH: if (div_last) state_next = ST_FIT;
      ST_FIT:    state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // ---------------- control outputs ----------------
  always_comb begin
    in_ready = 1'b0;
    div_d    = sh;
    mul_a    = fh;
    mul_b    = sw;
    div_last = 1'b0;
    unique case (state)
      ST_IDLE:   in_ready = 1'b1;
      ST_DIV_SW, ST_DIV_SH: begin
        div_d    = {{(SCL_W-SCALE_W){1'b0}}, scale_factor};
        div_last = (cnt == SRC_LAST);
      end
      ST_PRE_HW: div_d = sh;
      ST_DIV_HW: begin
        div_d    = sh;
        div_last = (cnt == FIT_LAST);
      end
      ST_MUL_VH: begin
        mul_a = fw;
        mul_b = sh;
      end
      ST_PRE_VH: div_d = sw;
      ST_DIV_VH: begin
        div_d    = sw;
        div_last = (cnt == FIT_LAST);
      end
      default: ;
    endcase
  end

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign div_t    = {rem, dq[SCL_W-1]};
  assign div_ge   = (div_t >= {1'b0, div_d});
  assign rem_next = div_ge ? SCL_W'(div_t - {1'b0, div_d}) : div_t[SCL_W-1:0];
  assign dq_next  = {dq[SCL_W-2:0], div_ge};

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // quotient would not fit in 20 bits: high part of the dividend >= divisor
  assign pre_sat = (prod[PROD_W-1:FRAME_W] >= div_d);

  assign sw_sat = (sw > SCL_W'(SIZE_MAX)) ? SIZE_MAX : sw[FRAME_W-1:0];
  assign sh_sat = (sh > SCL_W'(SIZE_MAX)) ? SIZE_MAX : sh[FRAME_W-1:0];

  always_comb begin
    dw_fit = fw;
    dh_fit = fh;
    unique case (fit_mode)
      FIT_FILL: ;
      FIT_CONTAIN: begin
        dw_fit = (hw < fw) ? hw : fw;
        dh_fit = (vh < fh) ? vh : fh;
      end
      FIT_COVER: begin
        dw_fit = (hw > fw) ? hw : fw;
        dh_fit = (vh > fh) ? vh : fh;
      end
      FIT_MATCH_W: dh_fit = vh;
      FIT_MATCH_H: dw_fit = hw;
      FIT_NONE, FIT_TOP_LEFT: begin
        dw_fit = sw_sat;
        dh_fit = sh_sat;
      end
      FIT_SCALE_DOWN: begin
        if (sw < SCL_W'(fw) && sh < SCL_W'(fh)) begin
          dw_fit = sw_sat;
          dh_fit = sh_sat;
        end else begin
          dw_fit = (hw < fw) ? hw : fw;
          dh_fit = (vh < fh) ? vh : fh;
        end
      end
    endcase
  end

  // floor half of the difference; always fits in 20 signed bits
  assign diff_x = $signed({1'b0, fw}) - $signed({1'b0, dw});
  assign diff_y = $signed({1'b0, fh}) - $signed({1'b0, dh});

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      scale_factor <= SCALE_RESET;
      fit_mode     <= FIT_CONTAIN;
      out_valid    <= 1'b0;
      out_data     <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        if (cfg_index == CFG_SCALE_FACTOR) begin
          if (cfg_data != '0) scale_factor <= cfg_data;
        end else if (cfg_index == CFG_FIT_MODE) begin
          fit_mode <= fit_mode_t'(cfg_data[2:0]);
        end
      end
      if (state == ST_DONE && out_free) begin
        out_valid       <= 1'b1;
        out_data.status <= zero_size;
        if (!zero_size) begin
          out_data.dst_x      <= corner ? '0 : diff_x[FRAME_W:1];
          out_data.dst_y      <= corner ? '0 : diff_y[FRAME_W:1];
          out_data.dst_width  <= dw;
          out_data.dst_height <= dh;
        end
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          src_h <= in_data.src_height;
          fw    <= in_data.frame_width;
          fh    <= in_data.frame_height;
          rem   <= '0;
          dq    <= {in_data.src_width, {(SCL_W-SRC_W){1'b0}}};
          cnt   <= '0;
        end
      end
      ST_DIV_SW: begin
        if (div_last) begin
          sw  <= dq_next;
          rem <= '0;
          dq  <= {src_h, {(SCL_W-SRC_W){1'b0}}};
          cnt <= '0;
        end else begin
          rem <= rem_next;
          dq  <= dq_next;
          cnt <= cnt + 1'b1;
        end
      end
      ST_DIV_SH: begin
        rem <= rem_next;
        dq  <= dq_next;
        cnt <= cnt + 1'b1;
        if (div_last) sh <= dq_next;
      end
      ST_CHECK:  zero_size <= (sw == '0 || sh == '0);
      ST_MUL_HW, ST_MUL_VH: prod <= mul_p;
      ST_PRE_HW, ST_PRE_VH: begin
        if (pre_sat) begin
          if (state == ST_PRE_HW) hw <= SIZE_MAX;
          else vh <= SIZE_MAX;
        end
        rem <= prod[PROD_W-1:FRAME_W];
        dq  <= {prod[FRAME_W-1:0], {(SCL_W-FRAME_W){1'b0}}};
        cnt <= '0;
      end
      ST_DIV_HW, ST_DIV_VH: begin
        rem <= rem_next;
        dq  <= dq_next;
        cnt <= cnt + 1'b1;
        if (div_last) begin
          if (state == ST_DIV_HW) hw <= dq_next[FRAME_W-1:0];
          else vh <= dq_next[FRAME_W-1:0];
        end
      end
      ST_FIT: begin
        dw     <= dw_fit;
        dh     <= dh_fit;
        corner <= (fit_mode == FIT_TOP_LEFT);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // an accepted item keeps the block busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transfer");

  // a zero-size result repeats the held rectangle
  a_zero_holds_rect: assert property (@(posedge clk) disable iff (rst)
    state == ST_DONE && out_free && zero_size |=>
      out_data.status && $stable(out_data.dst_width) && $stable(out_data.dst_height)
      && $stable(out_data.dst_x) && $stable(out_data.dst_y))
    else $error("held rectangle changed on a zero-size item");

  // divider step counter stays within the dividend width
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV_SW || state == ST_DIV_SH) |-> cnt <= SRC_LAST)
    else $error("divider step counter overran");

  a_scale_nonzero: assert property (@(posedge clk) disable iff (rst)
    scale_factor != '0)
    else $error("scale divisor became zero");
`endif

endmodule

`default_nettype wire
